/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* rtl/sbs_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Shared widths, types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sbs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = 8;
	localparam int SIZE_W      = 9;
	localparam int BOUND_W     = 10;

	typedef logic signed [31:0]        word_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [SIZE_W-1:0]         count_t;
	typedef logic signed [BOUND_W-1:0] bound_t;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_SEARCH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic first;
		logic step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic exhausted;
		logic slot_free;
	} status_t;

endpackage

/* rtl/sbs_ctrl.sv */
// ----------------------------------------------------------------------------
// Binary search controller
// State machine that sequences loads, search setup and probe steps.
// ----------------------------------------------------------------------------
module sbs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            kind,
	input  sbs_pkg::status_t status,
	output logic            in_stall,
	output sbs_pkg::cmd_t   cmd
);

	sbs_pkg::state_t state_q;
	sbs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = (state_q != sbs_pkg::ST_IDLE);
		case (state_q)
			sbs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (kind == sbs_pkg::KIND_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = sbs_pkg::ST_INIT;
					end
				end
			end
			sbs_pkg::ST_INIT: begin
				cmd.first = 1'b1;
				if (status.exhausted) begin
					// Empty table: report not found as soon as the output is free.
					if (status.slot_free) begin
						cmd.finish = 1'b1;
						state_d    = sbs_pkg::ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = sbs_pkg::ST_SEARCH;
				end
			end
			sbs_pkg::ST_SEARCH: begin
				if (status.hit || status.exhausted) begin
					if (status.slot_free) begin
						cmd.finish = 1'b1;
						state_d    = sbs_pkg::ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = sbs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/sbs_datapath.sv */
// ----------------------------------------------------------------------------
// Binary search datapath
// Table memory, size register, search bounds, probe compare and result register.
// ----------------------------------------------------------------------------
module sbs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  sbs_pkg::cmd_t    cmd,
	input  sbs_pkg::idx_t    entry_index,
	input  sbs_pkg::word_t   item_value,
	input  logic             cfg_write,
	input  sbs_pkg::count_t  cfg_size,
	input  logic             out_stall,
	output sbs_pkg::status_t status,
	output logic             out_valid,
	output logic             found,
	output sbs_pkg::idx_t    position
);

	sbs_pkg::word_t  mem [sbs_pkg::TABLE_DEPTH];

	sbs_pkg::count_t used_size_q;
	sbs_pkg::word_t  key_q;
	sbs_pkg::word_t  rdata_q;
	sbs_pkg::bound_t lo_q;
	sbs_pkg::bound_t hi_q;
	sbs_pkg::idx_t   mid_q;
	logic            out_valid_q;
	logic            found_q;
	sbs_pkg::idx_t   position_q;

	sbs_pkg::count_t eff_size;
	sbs_pkg::bound_t hi_init;
	sbs_pkg::bound_t mid_ext;
	sbs_pkg::bound_t lo_n;
	sbs_pkg::bound_t hi_n;
	logic [sbs_pkg::IDX_W:0] sum;
	sbs_pkg::idx_t   mid_n;
	logic            hit;

	always_comb begin
		eff_size = (used_size_q > sbs_pkg::count_t'(sbs_pkg::TABLE_DEPTH))
			? sbs_pkg::count_t'(sbs_pkg::TABLE_DEPTH) : used_size_q;
		hi_init  = sbs_pkg::bound_t'({1'b0, eff_size}) - sbs_pkg::bound_t'(1);
		mid_ext  = sbs_pkg::bound_t'({2'b00, mid_q});
		hit      = !cmd.first && (rdata_q == key_q);

		// On the first step the initial bounds stand; later the last probe narrows them.
		if (cmd.first) begin
			lo_n = lo_q;
			hi_n = hi_q;
		end else if (key_q > rdata_q) begin
			lo_n = mid_ext + sbs_pkg::bound_t'(1);
			hi_n = hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = mid_ext - sbs_pkg::bound_t'(1);
		end

		// Both bounds lie within the table whenever the probe is used.
		sum   = {1'b0, lo_n[sbs_pkg::IDX_W-1:0]} + {1'b0, hi_n[sbs_pkg::IDX_W-1:0]};
		mid_n = sum[sbs_pkg::IDX_W:1];

		status.hit       = hit;
		status.exhausted = (lo_n > hi_n);
		status.slot_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[entry_index] <= item_value;
		end
		if (cmd.step) begin
			rdata_q <= mem[mid_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_size_q <= '0;
		end else if (cfg_write) begin
			used_size_q <= cfg_size;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= item_value;
			lo_q  <= '0;
			hi_q  <= hi_init;
		end
		if (cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
		if (cmd.finish) begin
			found_q    <= hit;
			position_q <= hit ? mid_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = position_q;

endmodule

/* rtl/sorted_table_binary_search_unit.sv */
// ----------------------------------------------------------------------------
// Sorted table binary search unit
// Holds a table of signed words in ascending order and answers key searches.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  kind, entry_index, item_value
//   output    out_valid / out_stall found, position
//   config    cfg_valid / cfg_ready used_size
//
// A load request writes the table directly, and loads may follow each other every
// cycle while no search holds the input. A search request passes a setup state and
// then one probe step per read of the single memory read port feeding the compare.
// The table memory has no reset; only control state and used_size are cleared.
// A finished result waits in the output register while the next request enters;
// a search only holds when its result finds that register still full and stalled.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	input  logic [7:0]      entry_index,
	input  logic signed [31:0] item_value,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            found,
	output logic [7:0]      position,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [8:0]      used_size
);

	sbs_pkg::cmd_t    cmd;
	sbs_pkg::status_t status;

	assign cfg_ready = 1'b1;

	sbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	sbs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_index (entry_index),
		.item_value  (item_value),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_size    (used_size),
		.out_stall   (out_stall),
		.status      (status),
		.out_valid   (out_valid),
		.found       (found),
		.position    (position)
	);

endmodule

/* rtl/sbs_checker.sv */
// ----------------------------------------------------------------------------
// Binary search port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [7:0]  position
);

	// A stalled result keeps its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(position))

	// A miss always reports position zero.
	`ASSERT_SAME(a_miss_pos, clk, arst_n, out_valid && !found, position == 8'd0)

	// Loads never block the next request.
	`ASSERT_NEXT(a_load_free, clk, arst_n, in_valid && !in_stall && (kind == sbs_pkg::KIND_LOAD), !in_stall)

	// A search request keeps the input stalled while it runs.
	`ASSERT_NEXT(a_search_busy, clk, arst_n, in_valid && !in_stall && (kind == sbs_pkg::KIND_SEARCH), in_stall)

	// A new result only appears at the end of a search.
	`ASSERT_SAME(a_result_src, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind sorted_table_binary_search_unit sbs_checker u_sbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.found     (found),
	.position  (position)
);
